@@ hdl/stfc_pkg.sv @@
// Shared types, constants and helper functions for the temperature fan curve block.
`default_nettype none

package stfc_pkg;

  // Field and register widths
  localparam int unsigned RAW_W      = 20;
  localparam int unsigned CALIB_W    = 16;
  localparam int unsigned COUNT_W    = 3;
  localparam int unsigned POINT_W    = 17;
  localparam int unsigned CFG_DATA_W = 17;
  localparam int unsigned DUTY_W     = 9;
  localparam int unsigned TEMP_W     = 15;

  // Datapath widths
  localparam int unsigned MUL_A_W    = 21;
  localparam int unsigned MUL_B_W    = 17;
  localparam int unsigned PROD_W     = 38;
  localparam int unsigned DIV_NUM_W  = 24;
  localparam int unsigned DIV_DEN_W  = 15;
  localparam int unsigned DIV_CNT_W  = 5;
  localparam int unsigned QUO_W      = 10;

  // Register indexes on the config port
  localparam int unsigned REG_CALIB_T1    = 0;
  localparam int unsigned REG_CALIB_T2    = 1;
  localparam int unsigned REG_CALIB_T3    = 2;
  localparam int unsigned REG_POINT_COUNT = 3;
  localparam int unsigned REG_POINT_BASE  = 4;

  // Reset values
  localparam logic [CALIB_W-1:0]        CALIB_T1_RESET   = 16'd27504;
  localparam logic signed [CALIB_W-1:0] CALIB_T2_RESET   = 16'sd26435;
  localparam logic signed [CALIB_W-1:0] CALIB_T3_RESET   = -16'sd1000;
  localparam logic [COUNT_W-1:0]        POINT_COUNT_RESET = 3'd4;
  localparam logic [DUTY_W-1:0]         LAST_DUTY_RESET  = 9'd20;

  // Temperature saturation limits, hundredths of a degree
  localparam logic signed [TEMP_W-1:0] TEMP_MIN = -15'sd4000;
  localparam logic signed [TEMP_W-1:0] TEMP_MAX = 15'sd8500;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_A,
    ST_MUL_B,
    ST_MUL_C,
    ST_TFINE,
    ST_TEMP,
    ST_SELECT,
    ST_PREP,
    ST_MUL_D,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_FINISH
  } stfc_state_t;

  // Operand pairs for the shared multiplier
  typedef enum logic [1:0] {
    MUL_A_T2,
    MUL_B_B,
    MUL_BB_T3,
    MUL_DY_DT
  } stfc_mul_sel_t;

  typedef struct packed {
    logic          load_raw;
    logic          mul_en;
    stfc_mul_sel_t mul_sel;
    logic          v1_en;
    logic          tfine_en;
    logic          temp_en;
    logic          sel_en;
    logic          prep_en;
    logic          div_start;
    logic          finish;
  } stfc_cmd_t;

  typedef struct packed {
    logic div_done;
  } stfc_status_t;

  // Breakpoint degrees times 100, by shift and add
  function automatic logic signed [15:0] point_centi(input logic [POINT_W-1:0] p);
    logic signed [15:0] deg;
    deg = 16'(signed'(p[7:0]));
    return (deg <<< 6) + (deg <<< 5) + (deg <<< 2);
  endfunction

  // Breakpoint reset values; points past the fourth clear
  function automatic logic [POINT_W-1:0] point_reset(input int k);
    logic [POINT_W-1:0] v;
    case (k)
      0:       v = 17'd16404;
      1:       v = 17'd32798;
      2:       v = 17'd49192;
      3:       v = 17'd65586;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

@@ hdl/stfc_divider.sv @@
// Restoring divider, one quotient bit per cycle, unsigned operands.
`default_nettype none

module stfc_divider (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             start,
  input  wire logic [stfc_pkg::DIV_NUM_W-1:0]   num,
  input  wire logic [stfc_pkg::DIV_DEN_W-1:0]   den,
  output logic      [stfc_pkg::QUO_W-1:0]       quo,
  output logic                                  done
);

  logic [stfc_pkg::DIV_DEN_W-1:0] rem;
  logic [stfc_pkg::DIV_NUM_W-1:0] shreg;
  logic [stfc_pkg::DIV_CNT_W-1:0] cnt;
  logic [stfc_pkg::DIV_DEN_W:0]   rem_sh;
  logic                           fits;
  logic [stfc_pkg::DIV_DEN_W:0]   rem_sub;

  // Trial subtract of the shifted remainder
  assign rem_sh  = {rem, shreg[stfc_pkg::DIV_NUM_W-1]};
  assign fits    = rem_sh >= {1'b0, den};
  assign rem_sub = rem_sh - {1'b0, den};

  // Iteration counter
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= stfc_pkg::DIV_CNT_W'(stfc_pkg::DIV_NUM_W);
    end else if (cnt != '0) begin
      cnt <= cnt - 1'b1;
    end
  end

  // Remainder and quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= '0;
      shreg <= num;
    end else if (cnt != '0) begin
      rem   <= fits ? rem_sub[stfc_pkg::DIV_DEN_W-1:0] : rem_sh[stfc_pkg::DIV_DEN_W-1:0];
      shreg <= {shreg[stfc_pkg::DIV_NUM_W-2:0], fits};
    end
  end

  assign quo  = shreg[stfc_pkg::QUO_W-1:0];
  assign done = (cnt == '0);

endmodule

`default_nettype wire

@@ hdl/stfc_datapath.sv @@
// Datapath: compensation, breakpoint search, interpolation and result registers.
`default_nettype none

module stfc_datapath #(
  parameter int MAX_POINTS = 4,
  parameter int DUTY_FULL  = 256
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire stfc_pkg::stfc_cmd_t                    cmd,
  output stfc_pkg::stfc_status_t                      status,
  input  wire logic [stfc_pkg::RAW_W-1:0]             raw_temperature,
  input  wire logic [stfc_pkg::CALIB_W-1:0]           calib_t1,
  input  wire logic signed [stfc_pkg::CALIB_W-1:0]    calib_t2,
  input  wire logic signed [stfc_pkg::CALIB_W-1:0]    calib_t3,
  input  wire logic [stfc_pkg::COUNT_W-1:0]           point_count,
  input  wire logic [stfc_pkg::POINT_W-1:0]           points [MAX_POINTS],
  output logic [stfc_pkg::DUTY_W-1:0]                 fan_duty,
  output logic signed [stfc_pkg::TEMP_W-1:0]          temperature_centi,
  output logic                                        duty_held
);

  localparam int CntW = $clog2(MAX_POINTS + 1);
  localparam logic signed [11:0] DutyFull = 12'(DUTY_FULL);

  logic [stfc_pkg::RAW_W-1:0]          raw;
  logic signed [18:0]                  a_val;
  logic signed [16:0]                  b_val;
  logic signed [stfc_pkg::MUL_A_W-1:0] mul_a;
  logic signed [stfc_pkg::MUL_B_W-1:0] mul_b;
  logic signed [stfc_pkg::PROD_W-1:0]  mul_p;
  logic signed [stfc_pkg::PROD_W-1:0]  prod;
  logic signed [26:0]                  v1;
  logic signed [27:0]                  tfine;
  logic signed [30:0]                  t5;
  logic signed [22:0]                  tsh;
  logic signed [stfc_pkg::TEMP_W-1:0]  temp;
  logic signed [stfc_pkg::TEMP_W-1:0]  temp_next;
  logic [CntW-1:0]                     n_eff;
  logic                                hit_c;
  logic                                last_c;
  logic signed [15:0]                  x0_c;
  logic signed [15:0]                  x1_c;
  logic [stfc_pkg::DUTY_W-1:0]         y0_c;
  logic [stfc_pkg::DUTY_W-1:0]         y1_c;
  logic                                found;
  logic                                is_last;
  logic signed [15:0]                  x0;
  logic signed [15:0]                  x1;
  logic [stfc_pkg::DUTY_W-1:0]         y0;
  logic [stfc_pkg::DUTY_W-1:0]         y1;
  logic signed [9:0]                   dy;
  logic signed [15:0]                  dt;
  logic signed [15:0]                  span;
  logic [stfc_pkg::DIV_DEN_W-1:0]      den;
  logic [stfc_pkg::PROD_W-1:0]         mag;
  logic                                neg;
  logic [stfc_pkg::QUO_W-1:0]          div_quo;
  logic signed [10:0]                  q_s;
  logic signed [11:0]                  cand;
  logic signed [11:0]                  clamped;
  logic [stfc_pkg::DUTY_W-1:0]         duty9;
  logic [stfc_pkg::DUTY_W-1:0]         last_duty;

  // Input capture
  always_ff @(posedge clk) begin
    if (cmd.load_raw) begin
      raw <= raw_temperature;
    end
  end

  // Compensation differences
  assign a_val = $signed({2'b00, raw[19:3]}) - $signed({2'b00, calib_t1, 1'b0});
  assign b_val = $signed({1'b0, raw[19:4]}) - $signed({1'b0, calib_t1});

  // Shared multiplier operand select
  always_comb begin
    case (cmd.mul_sel)
      stfc_pkg::MUL_A_T2: begin
        mul_a = stfc_pkg::MUL_A_W'(a_val);
        mul_b = stfc_pkg::MUL_B_W'(calib_t2);
      end
      stfc_pkg::MUL_B_B: begin
        mul_a = stfc_pkg::MUL_A_W'(b_val);
        mul_b = b_val;
      end
      stfc_pkg::MUL_BB_T3: begin
        mul_a = $signed({1'b0, prod[31:12]});
        mul_b = stfc_pkg::MUL_B_W'(calib_t3);
      end
      stfc_pkg::MUL_DY_DT: begin
        mul_a = stfc_pkg::MUL_A_W'(dy);
        mul_b = stfc_pkg::MUL_B_W'(dt);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Product register and compensation accumulators
  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod <= mul_p;
    end
    if (cmd.v1_en) begin
      v1 <= 27'(prod >>> 11);
    end
    if (cmd.tfine_en) begin
      tfine <= 28'(v1) + 28'(prod >>> 14);
    end
    if (cmd.temp_en) begin
      temp <= temp_next;
    end
  end

  // Scale to hundredths and saturate
  assign t5  = (31'(tfine) <<< 2) + 31'(tfine) + 31'sd128;
  assign tsh = 23'(t5 >>> 8);

  always_comb begin
    if (tsh < 23'(stfc_pkg::TEMP_MIN)) begin
      temp_next = stfc_pkg::TEMP_MIN;
    end else if (tsh > 23'(stfc_pkg::TEMP_MAX)) begin
      temp_next = stfc_pkg::TEMP_MAX;
    end else begin
      temp_next = stfc_pkg::TEMP_W'(tsh);
    end
  end

  // Points in use, forced into 1..MAX_POINTS
  always_comb begin
    if (point_count == '0) begin
      n_eff = CntW'(1);
    end else if (int'(point_count) > MAX_POINTS) begin
      n_eff = CntW'(MAX_POINTS);
    end else begin
      n_eff = CntW'(point_count);
    end
  end

  // Last point at or below the temperature, and its successor
  always_comb begin
    hit_c  = 1'b0;
    last_c = 1'b0;
    x0_c   = '0;
    y0_c   = '0;
    x1_c   = '0;
    y1_c   = '0;
    for (int k = 0; k < MAX_POINTS; k++) begin
      if ((k < int'(n_eff)) &&
          (stfc_pkg::point_centi(points[k]) <= 16'(temp))) begin
        hit_c  = 1'b1;
        last_c = (k + 1 == int'(n_eff));
        x0_c   = stfc_pkg::point_centi(points[k]);
        y0_c   = points[k][16:8];
        x1_c   = stfc_pkg::point_centi(points[(k + 1) % MAX_POINTS]);
        y1_c   = points[(k + 1) % MAX_POINTS][16:8];
      end
    end
  end

  assign span = x1 - x0;

  // Segment registers and interpolation operands
  always_ff @(posedge clk) begin
    if (cmd.sel_en) begin
      found   <= hit_c;
      is_last <= last_c;
      x0      <= x0_c;
      x1      <= x1_c;
      y0      <= y0_c;
      y1      <= y1_c;
    end
    if (cmd.prep_en) begin
      dy  <= $signed({1'b0, y1}) - $signed({1'b0, y0});
      dt  <= 16'(temp) - x0;
      den <= span[stfc_pkg::DIV_DEN_W-1:0];
    end
    if (cmd.div_start) begin
      neg <= prod[stfc_pkg::PROD_W-1];
    end
  end

  // Divide magnitude of the slope product
  assign mag = prod[stfc_pkg::PROD_W-1] ? 38'(-prod) : 38'(prod);

  stfc_divider u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (mag[stfc_pkg::DIV_NUM_W-1:0]),
    .den   (den),
    .quo   (div_quo),
    .done  (status.div_done)
  );

  // Final duty: held, last point, or interpolated, then clamped
  assign q_s = neg ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});

  always_comb begin
    if (!found) begin
      cand = $signed({3'b000, last_duty});
    end else if (is_last) begin
      cand = $signed({3'b000, y0});
    end else begin
      cand = $signed({3'b000, y0}) + 12'(q_s);
    end
    if (cand < 12'sd1) begin
      clamped = 12'sd1;
    end else if (cand > DutyFull) begin
      clamped = DutyFull;
    end else begin
      clamped = cand;
    end
  end

  assign duty9 = clamped[stfc_pkg::DUTY_W-1:0];

  // Remembered duty
  always_ff @(posedge clk) begin
    if (rst) begin
      last_duty <= stfc_pkg::LAST_DUTY_RESET;
    end else if (cmd.finish) begin
      last_duty <= duty9;
    end
  end

  // Result word register
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      fan_duty          <= duty9;
      temperature_centi <= temp;
      duty_held         <= !found;
    end
  end

endmodule

`default_nettype wire

@@ hdl/stfc_ctrl.sv @@
// Controller state machine: sequences the datapath and runs both handshakes.
`default_nettype none

module stfc_ctrl (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    sample_valid,
  output logic                         sample_stall,
  output logic                         result_valid,
  input  wire logic                    result_stall,
  output stfc_pkg::stfc_cmd_t          cmd,
  input  wire stfc_pkg::stfc_status_t  status
);

  stfc_pkg::stfc_state_t state;
  stfc_pkg::stfc_state_t state_next;
  logic                  result_valid_next;

  // State and output-valid registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= stfc_pkg::ST_IDLE;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= result_valid_next;
    end
  end

  assign sample_stall = (state != stfc_pkg::ST_IDLE);

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.mul_sel = stfc_pkg::MUL_A_T2;
    case (state)
      stfc_pkg::ST_IDLE: begin
        if (sample_valid) begin
          cmd.load_raw = 1'b1;
          state_next   = stfc_pkg::ST_MUL_A;
        end
      end
      stfc_pkg::ST_MUL_A: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = stfc_pkg::MUL_A_T2;
        state_next  = stfc_pkg::ST_MUL_B;
      end
      stfc_pkg::ST_MUL_B: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = stfc_pkg::MUL_B_B;
        cmd.v1_en   = 1'b1;
        state_next  = stfc_pkg::ST_MUL_C;
      end
      stfc_pkg::ST_MUL_C: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = stfc_pkg::MUL_BB_T3;
        state_next  = stfc_pkg::ST_TFINE;
      end
      stfc_pkg::ST_TFINE: begin
        cmd.tfine_en = 1'b1;
        state_next   = stfc_pkg::ST_TEMP;
      end
      stfc_pkg::ST_TEMP: begin
        cmd.temp_en = 1'b1;
        state_next  = stfc_pkg::ST_SELECT;
      end
      stfc_pkg::ST_SELECT: begin
        cmd.sel_en = 1'b1;
        state_next = stfc_pkg::ST_PREP;
      end
      stfc_pkg::ST_PREP: begin
        cmd.prep_en = 1'b1;
        state_next  = stfc_pkg::ST_MUL_D;
      end
      stfc_pkg::ST_MUL_D: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = stfc_pkg::MUL_DY_DT;
        state_next  = stfc_pkg::ST_DIV_START;
      end
      stfc_pkg::ST_DIV_START: begin
        cmd.div_start = 1'b1;
        state_next    = stfc_pkg::ST_DIV_WAIT;
      end
      stfc_pkg::ST_DIV_WAIT: begin
        if (status.div_done) begin
          state_next = stfc_pkg::ST_FINISH;
        end
      end
      stfc_pkg::ST_FINISH: begin
        // load the result register once it is free or being emptied
        if (!result_valid || !result_stall) begin
          cmd.finish = 1'b1;
          state_next = stfc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = stfc_pkg::ST_IDLE;
      end
    endcase
  end

  // Result word valid
  always_comb begin
    if (cmd.finish) begin
      result_valid_next = 1'b1;
    end else if (result_valid && !result_stall) begin
      result_valid_next = 1'b0;
    end else begin
      result_valid_next = result_valid;
    end
  end

endmodule

`default_nettype wire

@@ hdl/stfc_cfg_regs.sv @@
// Configuration register file: calibration words, point count and breakpoints.
`default_nettype none

module stfc_cfg_regs #(
  parameter int MAX_POINTS = 4
) (
  input  wire logic                                           clk,
  input  wire logic                                           rst,
  input  wire logic                                           cfg_valid,
  output logic                                                cfg_ready,
  input  wire logic [$clog2(stfc_pkg::REG_POINT_BASE + MAX_POINTS)-1:0] cfg_index,
  input  wire logic [stfc_pkg::CFG_DATA_W-1:0]                cfg_data,
  output logic [stfc_pkg::CALIB_W-1:0]                        calib_t1,
  output logic signed [stfc_pkg::CALIB_W-1:0]                 calib_t2,
  output logic signed [stfc_pkg::CALIB_W-1:0]                 calib_t3,
  output logic [stfc_pkg::COUNT_W-1:0]                        point_count,
  output logic [stfc_pkg::POINT_W-1:0]                        points [MAX_POINTS]
);

  localparam int CfgIdxW = $clog2(stfc_pkg::REG_POINT_BASE + MAX_POINTS);
  localparam int SelW    = $clog2(MAX_POINTS);

  logic               wr;
  logic               pt_hit;
  logic [CfgIdxW-1:0] pt_off;
  logic [SelW-1:0]    pt_slot;

  assign cfg_ready = 1'b1;
  assign wr        = cfg_valid && cfg_ready;

  // Breakpoint address decode
  assign pt_hit  = ({1'b0, cfg_index} >= (CfgIdxW + 1)'(stfc_pkg::REG_POINT_BASE)) &&
                   ({1'b0, cfg_index} < (CfgIdxW + 1)'(stfc_pkg::REG_POINT_BASE + MAX_POINTS));
  assign pt_off  = cfg_index - CfgIdxW'(stfc_pkg::REG_POINT_BASE);
  assign pt_slot = pt_off[SelW-1:0];

  // Scalar registers
  always_ff @(posedge clk) begin
    if (rst) begin
      calib_t1    <= stfc_pkg::CALIB_T1_RESET;
      calib_t2    <= stfc_pkg::CALIB_T2_RESET;
      calib_t3    <= stfc_pkg::CALIB_T3_RESET;
      point_count <= stfc_pkg::POINT_COUNT_RESET;
    end else if (wr) begin
      if (cfg_index == CfgIdxW'(stfc_pkg::REG_CALIB_T1)) begin
        calib_t1 <= cfg_data[stfc_pkg::CALIB_W-1:0];
      end
      if (cfg_index == CfgIdxW'(stfc_pkg::REG_CALIB_T2)) begin
        calib_t2 <= $signed(cfg_data[stfc_pkg::CALIB_W-1:0]);
      end
      if (cfg_index == CfgIdxW'(stfc_pkg::REG_CALIB_T3)) begin
        calib_t3 <= $signed(cfg_data[stfc_pkg::CALIB_W-1:0]);
      end
      if (cfg_index == CfgIdxW'(stfc_pkg::REG_POINT_COUNT)) begin
        point_count <= cfg_data[stfc_pkg::COUNT_W-1:0];
      end
    end
  end

  // Breakpoint registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < MAX_POINTS; k++) begin
        points[k] <= stfc_pkg::point_reset(k);
      end
    end else if (wr && pt_hit) begin
      points[pt_slot] <= cfg_data[stfc_pkg::POINT_W-1:0];
    end
  end

endmodule

`default_nettype wire

@@ hdl/sensor_temperature_fan_curve.sv @@
// Raw sensor temperature to compensated temperature and fan duty from a breakpoint curve.
// A new sample word is stalled while the previous one is processed: one word at a time.
// Word rate is set by the 24-step divider, the shared multiplier and any result_stall.
// A waiting result word does not block the next sample; it sits in the output register.
// Sync reset rst: config, control state and result_valid take defaults; last duty becomes 20.
`default_nettype none

module sensor_temperature_fan_curve #(
  parameter int MAX_POINTS = 4,
  parameter int DUTY_FULL  = 256
) (
  input  wire logic                                                  clk,
  input  wire logic                                                  rst,
  input  wire logic                                                  sample_valid,
  output logic                                                       sample_stall,
  input  wire logic [stfc_pkg::RAW_W-1:0]                            raw_temperature,
  output logic                                                       result_valid,
  input  wire logic                                                  result_stall,
  output logic [stfc_pkg::DUTY_W-1:0]                                fan_duty,
  output logic signed [stfc_pkg::TEMP_W-1:0]                         temperature_centi,
  output logic                                                       duty_held,
  input  wire logic                                                  cfg_valid,
  output logic                                                       cfg_ready,
  input  wire logic [$clog2(stfc_pkg::REG_POINT_BASE + MAX_POINTS)-1:0] cfg_index,
  input  wire logic [stfc_pkg::CFG_DATA_W-1:0]                       cfg_data
);

  stfc_pkg::stfc_cmd_t              cmd;
  stfc_pkg::stfc_status_t           status;
  logic [stfc_pkg::CALIB_W-1:0]        calib_t1;
  logic signed [stfc_pkg::CALIB_W-1:0] calib_t2;
  logic signed [stfc_pkg::CALIB_W-1:0] calib_t3;
  logic [stfc_pkg::COUNT_W-1:0]        point_count;
  logic [stfc_pkg::POINT_W-1:0]        points [MAX_POINTS];

  // Config registers
  stfc_cfg_regs #(
    .MAX_POINTS (MAX_POINTS)
  ) u_cfg (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .calib_t1    (calib_t1),
    .calib_t2    (calib_t2),
    .calib_t3    (calib_t3),
    .point_count (point_count),
    .points      (points)
  );

  // Sequencer
  stfc_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .cmd          (cmd),
    .status       (status)
  );

  // Arithmetic
  stfc_datapath #(
    .MAX_POINTS (MAX_POINTS),
    .DUTY_FULL  (DUTY_FULL)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .status            (status),
    .raw_temperature   (raw_temperature),
    .calib_t1          (calib_t1),
    .calib_t2          (calib_t2),
    .calib_t3          (calib_t3),
    .point_count       (point_count),
    .points            (points),
    .fan_duty          (fan_duty),
    .temperature_centi (temperature_centi),
    .duty_held         (duty_held)
  );

endmodule

`default_nettype wire
